// ----- src/four_level_page_walker_top_defines.svh -----
// Assertion macros for the page walker
`ifndef FOUR_LEVEL_PAGE_WALKER_TOP_DEFINES_SVH
`define FOUR_LEVEL_PAGE_WALKER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet in reset
`define FLPW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flpw check failed: same-cycle implication");

// Next-cycle implication, sampled on clk, quiet in reset
`define FLPW_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flpw check failed: next-cycle implication");

`endif

// ----- src/flpw_pkg.sv -----
package flpw_pkg;

    // Widths
    localparam int PHYS_ADDR_BITS = 48;
    localparam int VA_W           = 48;
    localparam int DATA_W         = 64;
    localparam int OUT_W          = 49;
    localparam int SUM_W          = ((PHYS_ADDR_BITS > VA_W) ? PHYS_ADDR_BITS : VA_W) + 1;
    localparam int IDX_W          = 9;
    localparam int PAGE_SHIFT     = 12;

    // Entry bits
    localparam int PRESENT_BIT = 0;
    localparam int PS_BIT      = 7;

    // Input word type
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_RESP  = 1'b1;

    // Walk level: idle or the table whose entry is awaited
    typedef logic [2:0] level_t;
    localparam level_t LVL_IDLE = 3'd0;
    localparam level_t LVL_PT   = 3'd1;
    localparam level_t LVL_PD   = 3'd2;
    localparam level_t LVL_PDPT = 3'd3;
    localparam level_t LVL_PML4 = 3'd4;

    typedef enum logic [1:0] {
        KIND_REQ     = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_BADRESP = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PSZ_4K = 2'd0,
        PSZ_2M = 2'd1,
        PSZ_1G = 2'd2
    } psize_t;

    // One result word
    typedef struct packed {
        kind_t              kind;
        logic [OUT_W-1:0]   mem_addr;
        logic [OUT_W-1:0]   phys_addr;
        logic               fault;
        psize_t             page_size;
    } result_t;

endpackage

// ----- src/flpw_step.sv -----
module flpw_step (
    input  logic                          func,
    input  logic [flpw_pkg::VA_W-1:0]     virt_addr,
    input  logic [flpw_pkg::VA_W-1:0]     table_base,
    input  logic [flpw_pkg::DATA_W-1:0]   read_data,
    input  flpw_pkg::level_t              walk_level,
    input  logic [flpw_pkg::VA_W-1:0]     saved_vaddr,
    output flpw_pkg::result_t             res,
    output flpw_pkg::level_t              level_next,
    output logic [flpw_pkg::VA_W-1:0]     vaddr_next
);
    import flpw_pkg::*;

    logic [SUM_W-1:0] frame;
    logic [IDX_W-1:0] next_idx;
    logic [SUM_W-1:0] start_addr;
    logic [SUM_W-1:0] next_addr;
    logic [SUM_W-1:0] phys_1g;
    logic [SUM_W-1:0] phys_2m;
    logic [SUM_W-1:0] phys_4k;
    logic             present;
    logic             ps;

    // Entry frame and page offsets
    always_comb
    begin
        frame = '0;
        frame[PHYS_ADDR_BITS-1:PAGE_SHIFT] = read_data[PHYS_ADDR_BITS-1:PAGE_SHIFT];
        present = read_data[PRESENT_BIT];
        ps      = read_data[PS_BIT];
        phys_1g = frame + SUM_W'(saved_vaddr[29:0]);
        phys_2m = frame + SUM_W'(saved_vaddr[20:0]);
        phys_4k = frame + SUM_W'(saved_vaddr[11:0]);
    end

    // Index of the next table down
    always_comb
    begin
        case (walk_level)
            LVL_PML4: next_idx = saved_vaddr[38:30];
            LVL_PDPT: next_idx = saved_vaddr[29:21];
            LVL_PD:   next_idx = saved_vaddr[20:12];
            default:  next_idx = '0;
        endcase
    end

    assign start_addr = SUM_W'(table_base) + SUM_W'({virt_addr[47:39], 3'b000});
    assign next_addr  = frame + SUM_W'({next_idx, 3'b000});

    // One walk step
    always_comb
    begin
        res.kind      = KIND_REQ;
        res.mem_addr  = '0;
        res.phys_addr = '0;
        res.fault     = 1'b0;
        res.page_size = PSZ_4K;
        level_next    = walk_level;
        vaddr_next    = saved_vaddr;
        if (func == FUNC_START)
        begin
            vaddr_next = virt_addr;
            if (start_addr == '0)
            begin
                res.kind   = KIND_DONE;
                res.fault  = 1'b1;
                level_next = LVL_IDLE;
            end
            else
            begin
                res.mem_addr = start_addr[OUT_W-1:0];
                level_next   = LVL_PML4;
            end
        end
        else if (walk_level inside {[LVL_PT:LVL_PML4]})
        begin
            if (read_data == '0 || !present)
            begin
                res.kind   = KIND_DONE;
                res.fault  = 1'b1;
                level_next = LVL_IDLE;
            end
            else if (walk_level == LVL_PDPT && ps)
            begin
                res.kind      = KIND_DONE;
                res.phys_addr = phys_1g[OUT_W-1:0];
                res.page_size = PSZ_1G;
                level_next    = LVL_IDLE;
            end
            else if (walk_level == LVL_PD && ps)
            begin
                res.kind      = KIND_DONE;
                res.phys_addr = phys_2m[OUT_W-1:0];
                res.page_size = PSZ_2M;
                level_next    = LVL_IDLE;
            end
            else if (walk_level == LVL_PT)
            begin
                res.kind      = KIND_DONE;
                res.phys_addr = phys_4k[OUT_W-1:0];
                res.page_size = PSZ_4K;
                level_next    = LVL_IDLE;
            end
            else if (next_addr == '0)
            begin
                res.kind   = KIND_DONE;
                res.fault  = 1'b1;
                level_next = LVL_IDLE;
            end
            else
            begin
                res.mem_addr = next_addr[OUT_W-1:0];
                level_next   = walk_level - 3'd1;
            end
        end
        else
        begin
            // response with no walk running
            res.kind = KIND_BADRESP;
        end
    end

endmodule

// ----- src/four_level_page_walker_top.sv -----
// A word accepted into the input register passes through the walk step logic
// into the result register, from which it is taken when result_stall is low.
// Throughput: one word per cycle; the input register refills while the result
// register drains, so only a stalled result register holds the input side.
// Reset (rst_n low, asynchronous): both valid flags clear, the walk level
// returns to idle and the saved virtual address clears.
`include "four_level_page_walker_top_defines.svh"

module four_level_page_walker_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          func,
    input  logic [flpw_pkg::VA_W-1:0]     virt_addr,
    input  logic [flpw_pkg::VA_W-1:0]     table_base,
    input  logic [flpw_pkg::DATA_W-1:0]   read_data,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [1:0]                    kind,
    output logic [flpw_pkg::OUT_W-1:0]    mem_addr,
    output logic [flpw_pkg::OUT_W-1:0]    phys_addr,
    output logic                          fault,
    output logic [1:0]                    page_size
);
    import flpw_pkg::*;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic                s1_func_reg;
    logic [VA_W-1:0]     s1_vaddr_reg;
    logic [VA_W-1:0]     s1_base_reg;
    logic [DATA_W-1:0]   s1_data_reg;
    logic                result_valid_reg;
    logic                result_valid_next;
    result_t             result_reg;
    result_t             step_res;
    level_t              walk_level_reg;
    level_t              walk_level_next;
    logic [VA_W-1:0]     saved_vaddr_reg;
    logic [VA_W-1:0]     saved_vaddr_next;
    logic                out_free;
    logic                s1_fire;
    logic                item_take;
    logic                chk_req_word;
    logic                chk_fault_word;
    logic                chk_fault_ok;
    logic                chk_done_fire;

    // Handshake
    assign out_free          = !result_valid_reg || !result_stall;
    assign s1_fire           = s1_valid_reg && out_free;
    assign item_stall        = s1_valid_reg && !out_free;
    assign item_take         = item_valid && !item_stall;
    assign s1_valid_next     = item_take || (s1_valid_reg && !out_free);
    assign result_valid_next = s1_fire || (result_valid_reg && result_stall);

    // Walk step logic
    flpw_step u_step (
        .func        (s1_func_reg),
        .virt_addr   (s1_vaddr_reg),
        .table_base  (s1_base_reg),
        .read_data   (s1_data_reg),
        .walk_level  (walk_level_reg),
        .saved_vaddr (saved_vaddr_reg),
        .res         (step_res),
        .level_next  (walk_level_next),
        .vaddr_next  (saved_vaddr_next)
    );

    // Control and walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            walk_level_reg   <= LVL_IDLE;
            saved_vaddr_reg  <= '0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            if (s1_fire)
            begin
                walk_level_reg  <= walk_level_next;
                saved_vaddr_reg <= saved_vaddr_next;
            end
        end
    end

    // Input word register
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            s1_func_reg  <= func;
            s1_vaddr_reg <= virt_addr;
            s1_base_reg  <= table_base;
            s1_data_reg  <= read_data;
        end
    end

    // Result word register
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            result_reg <= step_res;
        end
    end

    assign result_valid = result_valid_reg;
    assign kind         = result_reg.kind;
    assign mem_addr     = result_reg.mem_addr;
    assign phys_addr    = result_reg.phys_addr;
    assign fault        = result_reg.fault;
    assign page_size    = result_reg.page_size;

    // Check terms
    assign chk_req_word   = result_valid_reg && result_reg.kind == KIND_REQ;
    assign chk_fault_word = result_valid_reg && result_reg.fault;
    assign chk_fault_ok   = result_reg.kind == KIND_DONE && result_reg.phys_addr == '0
                            && result_reg.page_size == PSZ_4K;
    assign chk_done_fire  = s1_fire && step_res.kind == KIND_DONE;

    // Checks
    `FLPW_ASSERT_IMP(a_req_addr_nonzero, chk_req_word, result_reg.mem_addr != '0)
    `FLPW_ASSERT_IMP(a_fault_is_done, chk_fault_word, chk_fault_ok)
    `FLPW_ASSERT_IMP(a_level_range, 1'b1, walk_level_reg <= LVL_PML4)
    `FLPW_ASSERT_NXT(a_done_goes_idle, chk_done_fire, walk_level_reg == LVL_IDLE)
    `FLPW_ASSERT_IMP(a_stall_only_full, item_stall, s1_valid_reg && result_valid_reg)

endmodule

// ----- test/four_level_page_walker_top_test.sv -----
module four_level_page_walker_top_test;

    import flpw_pkg::*;

    localparam int RANDOM_WORDS   = 600;
    localparam int DIRECTED_ROWS  = 25;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 8;

    // One directed stimulus word, with an optional hand-written result
    typedef struct {
        logic                word_func;
        logic [VA_W-1:0]     va;
        logic [VA_W-1:0]     base;
        logic [DATA_W-1:0]   entry;
        bit                  typed;
        result_t             want;
    } step_row_t;

    localparam result_t STRAY_RESP = '{KIND_BADRESP, '0, '0, 1'b0, PSZ_4K};
    localparam result_t WALK_FAULT = '{KIND_DONE, '0, '0, 1'b1, PSZ_4K};
    localparam result_t TOP_REQ_MAX = '{KIND_REQ, 49'h1_0000_0000_0FF7, '0, 1'b0, PSZ_4K};

    step_row_t directed_rows [DIRECTED_ROWS] = '{
        // response straight after reset
        '{FUNC_RESP,  48'h0,              48'h0,              64'hFFFF_FFFF_FFFF_FFFF, 1'b1, STRAY_RESP},
        // top entry at address zero: no read, immediate fault
        '{FUNC_START, 48'h0,              48'h0,              64'h0,                   1'b1, WALK_FAULT},
        '{FUNC_RESP,  48'h0,              48'h0,              64'h0,                   1'b1, STRAY_RESP},
        // largest base and index: carry into bit 48
        '{FUNC_START, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 64'h0,                   1'b1, TOP_REQ_MAX},
        '{FUNC_RESP,  48'h0,              48'h0,              64'h0,                   1'b1, WALK_FAULT},
        // all-ones entry at the top level, then not-present
        '{FUNC_START, 48'hFFFF_FFFF_FFFF, 48'h0000_0000_1000, 64'h0,                   1'b0, '0},
        '{FUNC_RESP,  48'h0,              48'h0,              64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
        '{FUNC_RESP,  48'h0,              48'h0,              64'hFFFF_FFFF_FFFF_FFFE, 1'b1, WALK_FAULT},
        // full walk to a 4 KiB page, size bit ignored at the last level
        '{FUNC_START, 48'h1234_5678_9ABC, 48'h0000_0010_0000, 64'h0,                   1'b0, '0},
        '{FUNC_RESP,  48'h0,              48'h0,              64'h0000_0000_0020_0003, 1'b0, '0},
        '{FUNC_RESP,  48'h0,              48'h0,              64'h0000_0000_0030_0003, 1'b0, '0},
        '{FUNC_RESP,  48'h0,              48'h0,              64'h0000_0000_0040_0003, 1'b0, '0},
        '{FUNC_RESP,  48'h0,              48'h0,              64'h8000_0000_0050_0083, 1'b0, '0},
        // 1 GiB page with all-ones entry and address
        '{FUNC_START, 48'hFFFF_FFFF_FFFF, 48'h0000_0010_0000, 64'h0,                   1'b0, '0},
        '{FUNC_RESP,  48'h0,              48'h0,              64'h0000_0000_0020_0001, 1'b0, '0},
        '{FUNC_RESP,  48'h0,              48'h0,              64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
        // 2 MiB page, frame bits above the physical width dropped
        '{FUNC_START, 48'h0000_4020_1FFF, 48'h0000_0010_0000, 64'h0,                   1'b0, '0},
        '{FUNC_RESP,  48'h0,              48'h0,              64'h0000_0000_0020_0003, 1'b0, '0},
        '{FUNC_RESP,  48'h0,              48'h0,              64'h0000_0000_0030_0003, 1'b0, '0},
        '{FUNC_RESP,  48'h0,              48'h0,              64'h0007_FFFF_FFE0_0081, 1'b0, '0},
        // restart in the middle of a walk
        '{FUNC_START, 48'h7FFF_0000_1000, 48'h0000_0040_0000, 64'h0,                   1'b0, '0},
        '{FUNC_RESP,  48'h0,              48'h0,              64'h0000_0000_0050_0003, 1'b0, '0},
        '{FUNC_START, 48'h0,              48'h0000_0000_1000, 64'h0,                   1'b0, '0},
        // present entry with frame zero and index zero: next read at address zero
        '{FUNC_RESP,  48'h0,              48'h0,              64'h0000_0000_0000_0001, 1'b1, WALK_FAULT},
        '{FUNC_RESP,  48'h0,              48'h0,              64'h0,                   1'b1, STRAY_RESP}
    };

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_stall;
    logic                func         = FUNC_START;
    logic [VA_W-1:0]     virt_addr    = '0;
    logic [VA_W-1:0]     table_base   = '0;
    logic [DATA_W-1:0]   read_data    = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [1:0]          kind;
    logic [OUT_W-1:0]    mem_addr;
    logic [OUT_W-1:0]    phys_addr;
    logic                fault;
    logic [1:0]          page_size;

    int                  gap_pct   = 0;
    int                  stall_pct = 0;
    int                  errors    = 0;

    // Walker state as predicted
    level_t              walk_lvl  = LVL_IDLE;
    logic [VA_W-1:0]     held_va   = '0;

    result_t             expected_words [$];

    four_level_page_walker_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .func         (func),
        .virt_addr    (virt_addr),
        .table_base   (table_base),
        .read_data    (read_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .mem_addr     (mem_addr),
        .phys_addr    (phys_addr),
        .fault        (fault),
        .page_size    (page_size)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predict the result word of one accepted input word and advance the walk
    function automatic result_t walk_step(logic f, logic [VA_W-1:0] va,
                                          logic [VA_W-1:0] base, logic [DATA_W-1:0] entry);
        result_t          r;
        logic [OUT_W-1:0] tbl;
        logic [OUT_W-1:0] frame;
        logic [OUT_W-1:0] addr;
        logic [VA_W-1:0]  shifted;
        level_t           nxt;
        r = '0;
        if (f == FUNC_START)
        begin
            held_va = va;
            tbl     = OUT_W'(base);
            nxt     = LVL_PML4;
        end
        else
        begin
            if (walk_lvl < LVL_PT || walk_lvl > LVL_PML4)
            begin
                r.kind = KIND_BADRESP;
                return r;
            end
            if (entry == '0 || !entry[PRESENT_BIT])
            begin
                walk_lvl = LVL_IDLE;
                r.kind   = KIND_DONE;
                r.fault  = 1'b1;
                return r;
            end
            frame = '0;
            frame[PHYS_ADDR_BITS-1:PAGE_SHIFT] = entry[PHYS_ADDR_BITS-1:PAGE_SHIFT];
            // leaf entries: large pages at the middle levels, 4 KiB at the bottom
            if (walk_lvl == LVL_PDPT && entry[PS_BIT])
            begin
                r.kind      = KIND_DONE;
                r.phys_addr = frame + OUT_W'(held_va[29:0]);
                r.page_size = PSZ_1G;
            end
            else if (walk_lvl == LVL_PD && entry[PS_BIT])
            begin
                r.kind      = KIND_DONE;
                r.phys_addr = frame + OUT_W'(held_va[20:0]);
                r.page_size = PSZ_2M;
            end
            else if (walk_lvl == LVL_PT)
            begin
                r.kind      = KIND_DONE;
                r.phys_addr = frame + OUT_W'(held_va[11:0]);
                r.page_size = PSZ_4K;
            end
            if (r.kind == KIND_DONE)
            begin
                walk_lvl = LVL_IDLE;
                return r;
            end
            tbl = frame;
            nxt = level_t'(walk_lvl - 3'd1);
        end
        // entry address of the next level; zero is never read
        shifted = held_va >> (PAGE_SHIFT + IDX_W * (int'(nxt) - 1));
        addr    = tbl + OUT_W'({shifted[IDX_W-1:0], 3'b000});
        if (addr == '0)
        begin
            walk_lvl = LVL_IDLE;
            r.kind   = KIND_DONE;
            r.fault  = 1'b1;
        end
        else
        begin
            walk_lvl   = nxt;
            r.kind     = KIND_REQ;
            r.mem_addr = addr;
        end
        return r;
    endfunction

    // Present one word after a random gap and hold it until accepted
    task automatic send_word(input logic f, input logic [VA_W-1:0] va,
                             input logic [VA_W-1:0] base, input logic [DATA_W-1:0] d);
        bit fire;
        while ($urandom_range(99) < gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        func       <= f;
        virt_addr  <= va;
        table_base <= base;
        read_data  <= d;
        fire = 1'b0;
        while (!fire)
        begin
            @(negedge clk);
            fire = !item_stall;
            @(posedge clk);
        end
    endtask

    // Result side back-pressure
    always @(posedge clk)
    begin
        result_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    // Compare each accepted result word with the oldest prediction
    always @(negedge clk)
    begin : check_result
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word: kind %0d mem_addr %h", kind, mem_addr);
                errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, kind);
                    errors++;
                end
                if (mem_addr !== want.mem_addr)
                begin
                    $error("mem_addr: expected %h, got %h", want.mem_addr, mem_addr);
                    errors++;
                end
                if (phys_addr !== want.phys_addr)
                begin
                    $error("phys_addr: expected %h, got %h", want.phys_addr, phys_addr);
                    errors++;
                end
                if (fault !== want.fault)
                begin
                    $error("fault: expected %0d, got %0d", want.fault, fault);
                    errors++;
                end
                if (page_size !== want.page_size)
                begin
                    $error("page_size: expected %0d, got %0d", want.page_size, page_size);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        result_t          want;
        logic             f;
        logic [VA_W-1:0]  va;
        logic [VA_W-1:0]  base;
        logic [DATA_W-1:0] d;
        int               pick;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words, no idling
        foreach (directed_rows[i])
        begin
            send_word(directed_rows[i].word_func, directed_rows[i].va,
                      directed_rows[i].base, directed_rows[i].entry);
            want = walk_step(directed_rows[i].word_func, directed_rows[i].va,
                             directed_rows[i].base, directed_rows[i].entry);
            if (directed_rows[i].typed)
                want = directed_rows[i].want;
            expected_words.push_back(want);
        end

        // random walks over four phases, with and without idling
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 47; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 47; end
                default: begin gap_pct = 21; stall_pct = 21; end
            endcase
            repeat (RANDOM_WORDS / 4)
            begin
                va   = {16'($urandom), 32'($urandom)};
                base = {16'($urandom), 32'($urandom)};
                d    = {$urandom, $urandom};
                // mostly well-formed walks, some restarts and stray responses
                if (walk_lvl == LVL_IDLE)
                    f = ($urandom_range(19) == 0) ? FUNC_RESP : FUNC_START;
                else
                    f = ($urandom_range(19) == 0) ? FUNC_START : FUNC_RESP;
                if (f == FUNC_START && $urandom_range(49) == 0)
                begin
                    base = '0;
                    va[47:39] = '0;
                end
                if (f == FUNC_RESP && walk_lvl != LVL_IDLE)
                begin
                    pick = $urandom_range(99);
                    if (pick < 5)
                        d = '0;
                    else if (pick < 12)
                        d[PRESENT_BIT] = 1'b0;
                    else
                    begin
                        d[PRESENT_BIT] = 1'b1;
                        d[PS_BIT]      = ($urandom_range(2) == 0);
                        if (pick < 15)
                            d[PHYS_ADDR_BITS-1:PAGE_SHIFT] = '0;
                    end
                end
                send_word(f, va, base, d);
                expected_words.push_back(walk_step(f, va, base, d));
            end
        end
        item_valid <= 1'b0;

        // drain
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
